// ===== hw/rtl/mxt_pkg.sv =====
// Shared types, token codes and keyword tables for the expression tokenizer.
// Used by mxt_front, mxt_emit, the top level and the testbench.
`default_nettype none

package mxt_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned KW_COUNT    = 9;
   localparam logic [2:0]  RUN_MAX     = 3'd6;

   localparam logic [4:0] KIND_NUM  = 5'd0;
   localparam logic [4:0] KIND_ADD  = 5'd1;
   localparam logic [4:0] KIND_SUB  = 5'd2;
   localparam logic [4:0] KIND_MUL  = 5'd3;
   localparam logic [4:0] KIND_DIV  = 5'd4;
   localparam logic [4:0] KIND_POW  = 5'd5;
   localparam logic [4:0] KIND_SIN  = 5'd6;
   localparam logic [4:0] KIND_COS  = 5'd7;
   localparam logic [4:0] KIND_TAN  = 5'd8;
   localparam logic [4:0] KIND_LPAR = 5'd9;
   localparam logic [4:0] KIND_RPAR = 5'd10;
   localparam logic [4:0] KIND_VARX = 5'd11;
   localparam logic [4:0] KIND_FACT = 5'd13;
   localparam logic [4:0] KIND_ASIN = 5'd14;
   localparam logic [4:0] KIND_ACOS = 5'd15;
   localparam logic [4:0] KIND_ATAN = 5'd16;
   localparam logic [4:0] KIND_LOG  = 5'd17;
   localparam logic [4:0] KIND_LN   = 5'd18;
   localparam logic [4:0] KIND_NONE = 5'd31;

   // constants scaled by 2^48 (value * 2^48)
   localparam logic [51:0] E_FRAC48  = 52'h2_B7E1_5162_8AED;
   localparam logic [51:0] PI_FRAC48 = 52'h3_243F_6A88_85A3;

   localparam longint unsigned POW10 [10] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
      64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000};

   // keyword text, first character in the lowest byte
   localparam logic [3:0][7:0] KW_TEXT [KW_COUNT] = '{
      {8'h00, "n", "i", "s"},
      {8'h00, "s", "o", "c"},
      {8'h00, "n", "a", "t"},
      {"n", "i", "s", "a"},
      {"s", "o", "c", "a"},
      {"n", "a", "t", "a"},
      {8'h00, 8'h00, "i", "p"},
      {8'h00, "g", "o", "l"},
      {8'h00, 8'h00, "n", "l"}};
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd2};
   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      KIND_SIN, KIND_COS, KIND_TAN, KIND_ASIN, KIND_ACOS, KIND_ATAN,
      KIND_NUM, KIND_LOG, KIND_LN};
   localparam logic [KW_COUNT-1:0] KW_IS_PI = 9'b0_0100_0000;

   typedef struct packed {
      logic [4:0]  kind;
      logic [47:0] value;
      logic        valid;
      logic        last;
      logic        done;
      logic        sat;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } push_type;

   typedef struct packed {
      logic       prefix;
      logic       complete;
      logic [4:0] kind;
      logic       is_pi;
   } kw_hit_type;

   function automatic kw_hit_type kw_lookup(input logic [3:0][7:0] cand,
                                            input logic [2:0] len);
      kw_hit_type r;
      logic       hit;
      r = '0;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit = (KW_LEN[i] >= len);
         for (int j = 0; j < 4; j++) begin
            if ((3'(j) < len) && (KW_TEXT[i][j] != cand[j])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            if (KW_LEN[i] == len) begin
               r.complete = 1'b1;
               r.kind     = KW_KIND[i];
               r.is_pi    = KW_IS_PI[i];
            end else begin
               r.prefix = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/math_expression_tokenizer_top.sv =====
// Top level of the arithmetic expression tokenizer.
// Instantiates mxt_front and mxt_emit; depends on mxt_pkg.
`default_nettype none

// Characters enter one per transfer on req_ (tlast marks the final character);
// tokens leave on rsp_ with tlast on the last token caused by a character.
// The scan sequencer in mxt_front does one action per cycle while the token queue is
// not full: a character takes a scan action and a closing action, and the closing
// action also takes the next character. Extra actions are needed for a finished number,
// a released minus, an implied multiply and each letter re-scanned after a keyword
// mismatch. The final character's closing action does not take a new character, and
// end of text also takes an action per flushed item and per re-scan pass of buffered
// letters. A full 4-entry token queue stalls scanning; otherwise scanning runs ahead
// of the consumer.
// Numbers are signed fixed point with FRACTION_BITS fraction bits.
module math_expression_tokenizer_top
   import mxt_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned MAX_TOKENS    = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_code
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // number_value
   output logic [7:0]       rsp_tuser,   // token_kind[4:0], token_valid, expression_done,
                                         // value_saturated
   output logic             rsp_tlast    // last_of_run
);

   push_type push;
   logic     full;

   mxt_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_TOKENS    (MAX_TOKENS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .full       (full),
      .push       (push)
   );

   mxt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mxt_emit.sv =====
// Back end: token queue and result stream formatting.
// Depends on mxt_pkg.
`default_nettype none

module mxt_emit
   import mxt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire push_type    push,
   output logic             full,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // number_value
   output logic [7:0]       rsp_tuser,   // token_kind[4:0], token_valid, expression_done,
                                         // value_saturated
   output logic             rsp_tlast    // last_of_run
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   token_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   rd_ff, rd_in;
   logic [PW-1:0]   wr_ff, wr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            pop;
   logic            wr_en;
   token_type       head;

   assign full       = (cnt_ff == CW'(QUEUE_DEPTH));
   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign wr_en      = push.valid && !full;
   assign head       = mem_ff[rd_ff];

   assign rsp_tdata = head.value;
   assign rsp_tuser = {head.sat, head.done, head.valid, head.kind};
   assign rsp_tlast = head.last;

   always_comb begin
      rd_in  = pop   ? rd_ff + 1'b1 : rd_ff;
      wr_in  = wr_en ? wr_ff + 1'b1 : wr_ff;
      cnt_in = cnt_ff + CW'(wr_en) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ff] <= push.tok;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mxt_front.sv =====
// Front end: character intake, replay buffer and scan sequencer; depends on mxt_pkg.
// One scan action per cycle unless the queue is full; finished tokens go to mxt_emit.
`default_nettype none

module mxt_front
   import mxt_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned MAX_TOKENS    = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        full,
   output push_type         push
);

   localparam int unsigned IP_W = 48 - FRACTION_BITS;
   localparam int unsigned TW   = $clog2(MAX_TOKENS + 1);
   localparam logic [IP_W+3:0] INT_TOP =
      (IP_W+4)'((64'd1 << (47 - FRACTION_BITS)) - 64'd1);
   localparam logic [51:0] E_Q =
      (E_FRAC48 + (52'd1 << (47 - FRACTION_BITS))) >> (48 - FRACTION_BITS);
   localparam logic [51:0] PI_Q =
      (PI_FRAC48 + (52'd1 << (47 - FRACTION_BITS))) >> (48 - FRACTION_BITS);
   localparam logic signed [48:0] TOP48 = 49'sh0_7FFF_FFFF_FFFF;

   // rounded fraction digit weights, place k, digit m
   logic [47:0] frac_q [10][10];
   for (genvar gk = 0; gk < 10; gk++) begin : g_place
      for (genvar gm = 0; gm < 10; gm++) begin : g_digit
         localparam longint unsigned QV = (gk == 0) ? 64'd0 :
            (gm * (64'd2 << FRACTION_BITS) + POW10[gk]) / (2 * POW10[gk]);
         assign frac_q[gk][gm] = QV[47:0];
      end
   end

   logic [3:0][7:0]    seq_ff, seq_in;
   logic [2:0]         slen_ff, slen_in;
   logic               end_ff, end_in;
   logic               active_ff, active_in;
   logic [4:0]         prev_ff, prev_in;
   logic               minus_ff, minus_in;
   logic               innum_ff, innum_in;
   logic signed [47:0] acc_ff, acc_in;
   logic [7:0]         fpos_ff, fpos_in;
   logic               sat_ff, sat_in;
   logic [2:0][7:0]    kbuf_ff, kbuf_in;
   logic [1:0]         kfill_ff, kfill_in;
   logic [TW-1:0]      tok_ff, tok_in;
   logic [2:0]         outn_ff, outn_in;
   token_type          stage_ff, stage_in;
   logic               stage_vld_ff, stage_vld_in;

   logic               go, accept;
   logic [7:0]         h;
   logic               is_digit, is_dot, is_op;
   logic [3:0]         mag;
   logic [3:0][7:0]    cand;
   kw_hit_type         kw, kw1;
   logic signed [47:0] base_acc;
   logic [7:0]         base_fpos, nf;
   logic               base_sat;
   logic [IP_W+3:0]    ipx, ipn;
   logic [47:0]        qsel;
   logic signed [48:0] fsum;
   logic               prev_mul, prev_open;

   logic               do_put, do_endnum, consume, finalize;
   logic [4:0]         put_kind;
   logic [47:0]        put_val;
   logic               put_sat;

   assign go         = active_ff && !full;
   assign req_tready = !full && (!active_ff || ((slen_ff == '0) && !end_ff));
   assign accept     = req_tvalid && req_tready;

   assign h        = seq_ff[0];
   assign is_digit = (h >= "0") && (h <= "9");
   assign is_dot   = (h == ".");
   assign is_op    = (h == "x") || (h == "X") || (h == "(") || (h == ")") || (h == "+") ||
                     (h == "*") || (h == "/") || (h == "^") || (h == "!") || (h == "e") ||
                     (h == "-");
   assign mag      = is_dot ? 4'd2 : 4'(h - 8'h30);

   always_comb begin
      cand[0] = (kfill_ff == 2'd0) ? h : kbuf_ff[0];
      cand[1] = (kfill_ff == 2'd1) ? h : ((kfill_ff > 2'd1) ? kbuf_ff[1] : 8'h00);
      cand[2] = (kfill_ff == 2'd2) ? h : ((kfill_ff > 2'd2) ? kbuf_ff[2] : 8'h00);
      cand[3] = (kfill_ff == 2'd3) ? h : 8'h00;
   end

   assign kw  = kw_lookup(cand, 3'(kfill_ff) + 3'd1);
   assign kw1 = kw_lookup({24'h0, h}, 3'd1);

   // digit accumulation
   assign base_acc  = innum_ff ? acc_ff  : '0;
   assign base_fpos = innum_ff ? fpos_ff : '0;
   assign base_sat  = innum_ff ? sat_ff  : 1'b0;
   assign nf        = (is_dot || (base_fpos != '0)) ?
                      ((base_fpos == 8'hFF) ? base_fpos : base_fpos + 8'd1) : base_fpos;
   assign ipx       = {4'b0, base_acc[47:FRACTION_BITS]};
   assign ipn       = (ipx << 3) + (ipx << 1) + (IP_W+4)'(mag);
   assign qsel      = frac_q[4'(nf - 8'd1)][mag];
   assign fsum      = is_dot ? ({base_acc[47], base_acc} - {1'b0, qsel})
                             : ({base_acc[47], base_acc} + {1'b0, qsel});

   assign prev_mul  = (prev_ff == KIND_NUM) || (prev_ff == KIND_RPAR) || (prev_ff == KIND_VARX);
   assign prev_open = (prev_ff == KIND_NONE) || (prev_ff == KIND_LPAR) ||
                      ((prev_ff >= KIND_ADD) && (prev_ff <= KIND_POW));

   always_comb begin
      seq_in       = seq_ff;
      slen_in      = slen_ff;
      end_in       = end_ff;
      active_in    = active_ff;
      prev_in      = prev_ff;
      minus_in     = minus_ff;
      innum_in     = innum_ff;
      acc_in       = acc_ff;
      fpos_in      = fpos_ff;
      sat_in       = sat_ff;
      kbuf_in      = kbuf_ff;
      kfill_in     = kfill_ff;
      tok_in       = tok_ff;
      outn_in      = outn_ff;
      stage_in     = stage_ff;
      stage_vld_in = stage_vld_ff;
      push.valid   = 1'b0;
      push.tok     = stage_ff;
      do_put       = 1'b0;
      do_endnum    = 1'b0;
      consume      = 1'b0;
      finalize     = 1'b0;
      put_kind     = KIND_NUM;
      put_val      = '0;
      put_sat      = 1'b0;

      if (go) begin
         if (slen_ff != '0) begin
            if (kfill_ff != 2'd0) begin
               if (kw.complete) begin
                  do_put = 1'b1;
                  if (minus_ff) begin
                     put_kind = KIND_SUB;
                     minus_in = 1'b0;
                  end else begin
                     put_kind = kw.kind;
                     put_val  = kw.is_pi ? PI_Q[47:0] : '0;
                     kfill_in = 2'd0;
                     consume  = 1'b1;
                  end
               end else if (kw.prefix) begin
                  case (kfill_ff)
                     2'd1:    kbuf_in[1] = h;
                     2'd2:    kbuf_in[2] = h;
                     default: kbuf_in    = kbuf_ff;
                  endcase
                  kfill_in = kfill_ff + 2'd1;
                  consume  = 1'b1;
               end else begin
                  // mismatch: drop first buffered letter, rescan the rest
                  kfill_in = 2'd0;
                  case (kfill_ff)
                     2'd2: begin
                        seq_in  = {seq_ff[2], seq_ff[1], h, kbuf_ff[1]};
                        slen_in = slen_ff + 3'd1;
                     end
                     2'd3: begin
                        seq_in  = {seq_ff[1], h, kbuf_ff[2], kbuf_ff[1]};
                        slen_in = slen_ff + 3'd2;
                     end
                     default: seq_in = seq_ff;
                  endcase
               end
            end else if (is_digit || is_dot) begin
               consume  = 1'b1;
               innum_in = 1'b1;
               fpos_in  = nf;
               sat_in   = base_sat;
               acc_in   = base_acc;
               if (nf == '0) begin
                  if (ipn > INT_TOP) begin
                     acc_in = {INT_TOP[IP_W-1:0], {FRACTION_BITS{1'b0}}};
                     sat_in = 1'b1;
                  end else begin
                     acc_in = {ipn[IP_W-1:0], {FRACTION_BITS{1'b0}}};
                  end
               end else if ((nf >= 8'd2) && (nf <= 8'd10)) begin
                  if (fsum > TOP48) begin
                     acc_in = TOP48[47:0];
                     sat_in = 1'b1;
                  end else begin
                     acc_in = fsum[47:0];
                  end
               end
            end else if (innum_ff) begin
               do_endnum = 1'b1;
            end else if (minus_ff && is_op) begin
               do_put   = 1'b1;
               put_kind = KIND_SUB;
               minus_in = 1'b0;
            end else begin
               consume = 1'b1;
               priority case (h)
                  "x", "X": begin
                     do_put   = 1'b1;
                     put_kind = prev_mul ? KIND_MUL : KIND_VARX;
                     consume  = !prev_mul;
                  end
                  "(": begin
                     do_put   = 1'b1;
                     put_kind = prev_mul ? KIND_MUL : KIND_LPAR;
                     consume  = !prev_mul;
                  end
                  ")": begin do_put = 1'b1; put_kind = KIND_RPAR; end
                  "+": begin do_put = 1'b1; put_kind = KIND_ADD;  end
                  "*": begin do_put = 1'b1; put_kind = KIND_MUL;  end
                  "/": begin do_put = 1'b1; put_kind = KIND_DIV;  end
                  "^": begin do_put = 1'b1; put_kind = KIND_POW;  end
                  "!": begin do_put = 1'b1; put_kind = KIND_FACT; end
                  "e": begin
                     do_put   = 1'b1;
                     put_kind = KIND_NUM;
                     put_val  = E_Q[47:0];
                  end
                  "-": begin
                     if (prev_open) begin
                        minus_in = 1'b1;
                     end else begin
                        do_put   = 1'b1;
                        put_kind = KIND_SUB;
                     end
                  end
                  default: begin
                     if (kw1.prefix) begin
                        kbuf_in[0] = h;
                        kfill_in   = 2'd1;
                     end
                  end
               endcase
            end
         end else if (end_ff) begin
            if (kfill_ff != 2'd0) begin
               kfill_in = 2'd0;
               seq_in   = {8'h00, 8'h00, kbuf_ff[2], kbuf_ff[1]};
               slen_in  = 3'(kfill_ff) - 3'd1;
            end else if (innum_ff) begin
               do_endnum = 1'b1;
            end else if (minus_ff) begin
               do_put   = 1'b1;
               put_kind = KIND_SUB;
               minus_in = 1'b0;
            end else begin
               finalize = 1'b1;
            end
         end else begin
            finalize = 1'b1;
         end
      end

      if (do_endnum) begin
         do_put   = 1'b1;
         put_kind = KIND_NUM;
         put_val  = minus_ff ? 48'(-acc_ff) : acc_ff;
         put_sat  = sat_ff;
         minus_in = 1'b0;
         innum_in = 1'b0;
         acc_in   = '0;
         fpos_in  = '0;
         sat_in   = 1'b0;
      end

      if (do_put) begin
         prev_in = put_kind;
         if ((tok_ff < TW'(MAX_TOKENS)) && (outn_ff < RUN_MAX)) begin
            if (stage_vld_ff) begin
               push.valid    = 1'b1;
               push.tok      = stage_ff;
               push.tok.last = 1'b0;
               push.tok.done = 1'b0;
            end
            stage_in     = '{kind: put_kind, value: put_val, valid: 1'b1,
                             last: 1'b0, done: 1'b0, sat: put_sat};
            stage_vld_in = 1'b1;
            tok_in       = tok_ff + 1'b1;
            outn_in      = outn_ff + 3'd1;
         end
      end

      if (consume) begin
         seq_in  = {8'h00, seq_ff[3], seq_ff[2], seq_ff[1]};
         slen_in = slen_ff - 3'd1;
      end

      if (finalize) begin
         if (stage_vld_ff) begin
            push.valid    = 1'b1;
            push.tok      = stage_ff;
            push.tok.last = 1'b1;
            push.tok.done = end_ff;
         end else if (end_ff) begin
            push.valid = 1'b1;
            push.tok   = '{kind: KIND_NUM, value: '0, valid: 1'b0,
                           last: 1'b1, done: 1'b1, sat: 1'b0};
         end
         stage_vld_in = 1'b0;
         active_in    = 1'b0;
         if (end_ff) begin
            prev_in  = KIND_NONE;
            minus_in = 1'b0;
            innum_in = 1'b0;
            acc_in   = '0;
            fpos_in  = '0;
            sat_in   = 1'b0;
            kfill_in = 2'd0;
            tok_in   = '0;
         end
      end

      if (accept) begin
         seq_in    = {24'h0, req_tdata};
         slen_in   = 3'd1;
         end_in    = req_tlast;
         active_in = 1'b1;
         outn_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slen_ff      <= '0;
         end_ff       <= 1'b0;
         active_ff    <= 1'b0;
         prev_ff      <= KIND_NONE;
         minus_ff     <= 1'b0;
         innum_ff     <= 1'b0;
         kfill_ff     <= 2'd0;
         tok_ff       <= '0;
         outn_ff      <= '0;
         stage_vld_ff <= 1'b0;
      end else begin
         slen_ff      <= slen_in;
         end_ff       <= end_in;
         active_ff    <= active_in;
         prev_ff      <= prev_in;
         minus_ff     <= minus_in;
         innum_ff     <= innum_in;
         kfill_ff     <= kfill_in;
         tok_ff       <= tok_in;
         outn_ff      <= outn_in;
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      acc_ff   <= acc_in;
      fpos_ff  <= fpos_in;
      sat_ff   <= sat_in;
      kbuf_ff  <= kbuf_in;
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mxt_checker.sv =====
// Port-level checks for math_expression_tokenizer_top, bound to the top level.
// Depends on nothing beyond the top level's ports.
`default_nettype none

module mxt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [7:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ req_tlast ^ (^req_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6] |-> rsp_tlast)
      else $error("expression end without run end");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[5] |-> rsp_tlast && rsp_tuser[6] &&
      (rsp_tuser[4:0] == 5'd0) && (rsp_tdata == 48'd0) && !rsp_tuser[7])
      else $error("malformed end marker");

   a_op_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[4:0] != 5'd0) |-> (rsp_tdata == 48'd0) && !rsp_tuser[7])
      else $error("non-number token carries a value");

endmodule

bind math_expression_tokenizer_top mxt_checker u_mxt_checker (.*);

`default_nettype wire

// ===== tb/tb_math_expression_tokenizer_top.sv =====
// Self-checking bench for math_expression_tokenizer_top: streams expression characters,
// predicts the token stream per character and compares every rsp transfer.
// Depends on mxt_pkg and the tokenizer RTL.
`default_nettype none

class token_scoreboard;
   typedef struct packed {
      logic [4:0]  kind;
      logic [47:0] value;
      logic        valid;
      logic        last;
      logic        done;
      logic        sat;
   } tok_t;

   tok_t expected_tokens[$];
   int   error_count;
   logic [4:0] prev_kind, prev2_kind;
   bit   minus_held, in_num, num_sat;
   longint num_acc;
   int   frac_pos;
   byte unsigned kw_buf[3];
   int   kw_fill;
   int   tok_count;
   tok_t run_q[$];

   function new();
      error_count = 0;
      clear_state();
   endfunction

   function void clear_state();
      prev_kind = mxt_pkg::KIND_NONE;
      prev2_kind = mxt_pkg::KIND_NONE;
      minus_held = 0;
      in_num = 0;
      num_sat = 0;
      num_acc = 0;
      frac_pos = 0;
      kw_fill = 0;
      tok_count = 0;
      kw_buf = '{0, 0, 0};
   endfunction

   function longint const_fixed(longint unsigned c48);
      return longint'((c48 + (64'd1 << 31)) >> 32);
   endfunction

   function void put(logic [4:0] kind, longint v, bit sat);
      tok_t t;
      if (tok_count < 128 && run_q.size() < 6) begin
         t = '0;
         t.kind = kind;
         t.value = v[47:0];
         t.valid = 1;
         t.sat = sat;
         run_q.push_back(t);
         tok_count++;
      end
      prev2_kind = prev_kind;
      prev_kind = kind;
   endfunction

   function void release_minus();
      if (minus_held) begin
         minus_held = 0;
         put(mxt_pkg::KIND_SUB, 0, 0);
      end
   endfunction

   function void emit_plain(logic [4:0] kind, longint v);
      release_minus();
      put(kind, v, 0);
   endfunction

   function void close_number();
      longint v;
      if (!in_num) return;
      v = num_acc;
      if (minus_held) begin
         minus_held = 0;
         v = -v;
      end
      put(mxt_pkg::KIND_NUM, v, num_sat);
      in_num = 0;
      num_acc = 0;
      frac_pos = 0;
      num_sat = 0;
   endfunction

   function void implied_mul();
      if (prev_kind == mxt_pkg::KIND_NUM || prev_kind == mxt_pkg::KIND_RPAR ||
          prev_kind == mxt_pkg::KIND_VARX)
         put(mxt_pkg::KIND_MUL, 0, 0);
   endfunction

   function void digit(byte unsigned c);
      longint unsigned ip, p, mag;
      longint q;
      if (!in_num) begin
         in_num = 1;
         num_acc = 0;
         frac_pos = 0;
         num_sat = 0;
      end
      if (c == "." || frac_pos > 0)
         if (frac_pos < 255) frac_pos++;
      if (frac_pos == 0) begin
         ip = longint'(num_acc) >> 16;
         ip = ip * 10 + (c - "0");
         if (ip > 64'h7FFF_FFFF) begin
            ip = 64'h7FFF_FFFF;
            num_sat = 1;
         end
         num_acc = ip << 16;
      end else if (frac_pos > 1 && frac_pos - 1 <= 9) begin
         p = mxt_pkg::POW10[frac_pos - 1];
         mag = (c == ".") ? 2 : (c - "0");
         q = (mag * (64'd2 << 16) + p) / (2 * p);
         num_acc += (c == ".") ? -q : q;
         if (num_acc > 64'sh7FFF_FFFF_FFFF) begin
            num_acc = 64'sh7FFF_FFFF_FFFF;
            num_sat = 1;
         end
      end
   endfunction

   // 0 none, 1 proper prefix, 2+i keyword i complete
   function int kw_match(byte unsigned cand[4], int n);
      int res, hit;
      res = 0;
      for (int i = 0; i < mxt_pkg::KW_COUNT; i++) begin
         hit = (mxt_pkg::KW_LEN[i] >= n);
         for (int j = 0; j < n; j++)
            if (mxt_pkg::KW_TEXT[i][j] != cand[j]) hit = 0;
         if (hit) begin
            if (mxt_pkg::KW_LEN[i] == n) return 2 + i;
            res = 1;
         end
      end
      return res;
   endfunction

   function void scan(byte unsigned c);
      byte unsigned cand[4];
      int n, m;
      cand = '{0, 0, 0, 0};
      if (kw_fill > 0) begin
         n = kw_fill;
         for (int i = 0; i < n; i++) cand[i] = kw_buf[i];
         cand[n] = c;
         n++;
         m = kw_match(cand, n);
         if (m == 1 && n < 4) begin
            kw_buf[kw_fill] = c;
            kw_fill++;
            return;
         end
         kw_fill = 0;
         if (m >= 2) begin
            if (mxt_pkg::KW_IS_PI[m - 2])
               emit_plain(mxt_pkg::KIND_NUM, const_fixed(64'h3243F6A8885A3));
            else
               emit_plain(mxt_pkg::KW_KIND[m - 2], 0);
            return;
         end
         for (int i = 1; i < n; i++) scan(cand[i]);
         return;
      end
      if ((c >= "0" && c <= "9") || c == ".") begin
         digit(c);
         return;
      end
      close_number();
      case (c)
         "x", "X": begin
            release_minus(); implied_mul(); put(mxt_pkg::KIND_VARX, 0, 0);
         end
         "(": begin
            release_minus(); implied_mul(); put(mxt_pkg::KIND_LPAR, 0, 0);
         end
         ")": emit_plain(mxt_pkg::KIND_RPAR, 0);
         "+": emit_plain(mxt_pkg::KIND_ADD, 0);
         "*": emit_plain(mxt_pkg::KIND_MUL, 0);
         "/": emit_plain(mxt_pkg::KIND_DIV, 0);
         "^": emit_plain(mxt_pkg::KIND_POW, 0);
         "!": emit_plain(mxt_pkg::KIND_FACT, 0);
         "e": emit_plain(mxt_pkg::KIND_NUM, const_fixed(64'h2B7E151628AED));
         "-": begin
            release_minus();
            if (prev_kind == mxt_pkg::KIND_NONE || prev_kind == mxt_pkg::KIND_LPAR ||
                (prev_kind >= mxt_pkg::KIND_ADD && prev_kind <= mxt_pkg::KIND_POW))
               minus_held = 1;
            else
               put(mxt_pkg::KIND_SUB, 0, 0);
         end
         default: begin
            cand[0] = c;
            if (kw_match(cand, 1) == 1) begin
               kw_buf[0] = c;
               kw_fill = 1;
            end
         end
      endcase
   endfunction

   function void note_char(byte unsigned c, bit eot);
      byte unsigned rest[3];
      int r;
      run_q.delete();
      scan(c);
      if (eot) begin
         while (kw_fill > 0) begin
            r = kw_fill - 1;
            for (int i = 0; i < r; i++) rest[i] = kw_buf[i + 1];
            kw_fill = 0;
            for (int i = 0; i < r; i++) scan(rest[i]);
         end
         close_number();
         release_minus();
         if (run_q.size() == 0) run_q.push_back('0);
         clear_state();
      end
      foreach (run_q[k]) begin
         run_q[k].last = (k == run_q.size() - 1);
         run_q[k].done = (k == run_q.size() - 1) && eot;
         expected_tokens.push_back(run_q[k]);
      end
   endfunction

   function void check_token(logic [47:0] data, logic [7:0] user, logic last);
      tok_t e;
      if (expected_tokens.size() == 0) begin
         $error("unexpected token transfer kind=%0d", user[4:0]);
         error_count++;
         return;
      end
      e = expected_tokens.pop_front();
      if (user[4:0] !== e.kind) begin
         $error("token_kind exp %0d got %0d", e.kind, user[4:0]); error_count++;
      end
      if (data !== e.value) begin
         $error("number_value exp %h got %h", e.value, data); error_count++;
      end
      if (user[5] !== e.valid) begin
         $error("token_valid exp %0d got %0d", e.valid, user[5]); error_count++;
      end
      if (last !== e.last) begin
         $error("last_of_run exp %0d got %0d", e.last, last); error_count++;
      end
      if (user[6] !== e.done) begin
         $error("expression_done exp %0d got %0d", e.done, user[6]); error_count++;
      end
      if (user[7] !== e.sat) begin
         $error("value_saturated exp %0d got %0d", e.sat, user[7]); error_count++;
      end
   endfunction
endclass

module tb_math_expression_tokenizer_top;
   import mxt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [7:0]  rsp_tuser;
   logic        rsp_tlast;

   token_scoreboard sb = new();
   bit quiet_phase = 0;
   bit stim_done = 0;
   int idle_cycles = 0;

   math_expression_tokenizer_top DUT (.*);

   always #4 clock = ~clock;

   // consumer with random stall bursts
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_token(rsp_tdata, rsp_tuser, rsp_tlast);
      if (!reset && ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // valid stays high between back-to-back transfers; it drops only for idling
   task automatic send_char(byte unsigned c, bit eot);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= c;
      req_tlast <= eot;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, eot);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic byte unsigned pick_char();
      string pool;
      int r;
      pool = "0123456789.0123456789+-*/^!()xXe-sinco tal gpa(x)";
      r = $urandom_range(0, 99);
      if (r < 8) return byte'($urandom_range(0, 255));
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   function automatic string pick_word();
      string words[12];
      words = '{"sin", "cos", "tan", "asin", "acos", "atan", "pi", "log", "ln", "as", "lo", "si"};
      return words[$urandom_range(0, 11)];
   endfunction

   initial begin
      string s;
      int sent, n;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_text("-3.14159265358+2x(x)");
      send_text("2(e-pi)*-x/4^1!");
      send_text("99999999999.5..7");
      send_text("sinacosasatanlnlogtacs");
      send_text(" ");
      send_text("-");
      send_char(8'hFF, 0);
      send_char(8'h00, 0);
      send_char(8'h80, 1);
      drain();

      sent = 0;
      while (sent < 250) begin
         if (sent > 200) quiet_phase = 1;
         s = "";
         n = $urandom_range(1, 14);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) s = {s, pick_word()};
            else s = {s, string'(pick_char())};
         end
         send_text(s);
         sent += s.len();
         if ($urandom_range(0, 9) == 0) drain();
      end
      // token cap: one long expression
      s = "";
      for (int i = 0; i < 70; i++) s = {s, "1+"};
      send_text({s, "2"});
      drain();
      repeat (40) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_tokens.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

`default_nettype wire
